@@ sv/tsu_pkg.sv @@
// Shared constants and types of the tick-sampled serial port with receive ring.
package tsu_pkg;

    localparam int RING_DEPTH = 32;
    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int FILL_W = 5;
    localparam int FILL_PAD_W = (IDX_W > FILL_W) ? IDX_W : FILL_W;

    localparam int BYTE_W = 8;
    localparam int PERIOD_W = 5;
    localparam int COUNT_W = 8;
    localparam int TX_FRAME_W = 10;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 5'd8;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 5'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 5'd25;
    localparam logic [COUNT_W-1:0] TX_FRAME_BITS = 8'd10;
    localparam logic [COUNT_W-1:0] RX_SAMPLES = 8'd9;

    localparam int IN_W = 12;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_W = 27;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic step;
        logic flush;
        logic pop;
        logic push;
    } ring_ctl_t;

    typedef struct packed {
        logic pop_valid;
        logic [BYTE_W-1:0] pop_data;
        logic head_valid;
        logic [BYTE_W-1:0] head_data;
        logic [FILL_W-1:0] fill_count;
        logic overrun;
    } ring_stat_t;

endpackage

@@ sv/tsu_ring.sv @@
// Receive ring: byte memory, read and write indices, overrun flag and registered reads.
module tsu_ring (
    input  logic clk,
    input  logic rst_n,
    input  tsu_pkg::ring_ctl_t ctl,
    input  logic [tsu_pkg::BYTE_W-1:0] push_data,
    output tsu_pkg::ring_stat_t stat
);
    import tsu_pkg::*;

    logic [BYTE_W-1:0] mem [RING_DEPTH];

    logic [IDX_W-1:0] wr_idx_reg;
    logic [IDX_W-1:0] wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] rd_idx_next;
    logic [IDX_W-1:0] rd_idx_popped;
    logic [IDX_W-1:0] wr_idx_pushed;
    logic overrun_reg;
    logic overrun_next;
    logic pop_valid_reg;
    logic pop_ok;
    logic head_bypass;
    logic [BYTE_W-1:0] pop_data_reg;
    logic [BYTE_W-1:0] head_data_reg;
    logic [IDX_W:0] fill_sum;
    logic [FILL_PAD_W-1:0] fill_pad;
    logic head_valid;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        next_idx = (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    always_comb
    begin
        pop_ok = !ctl.flush && ctl.pop && (wr_idx_reg != rd_idx_reg);
        rd_idx_popped = pop_ok ? next_idx(rd_idx_reg) : rd_idx_reg;
        wr_idx_pushed = next_idx(wr_idx_reg);
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_popped;
        overrun_next = overrun_reg;
        if (ctl.flush)
        begin
            wr_idx_next = '0;
            rd_idx_next = '0;
            overrun_next = 1'b0;
        end
        else if (ctl.push)
        begin
            wr_idx_next = wr_idx_pushed;
            if (wr_idx_pushed == rd_idx_popped)
            begin
                overrun_next = 1'b1;
                rd_idx_next = next_idx(rd_idx_popped);
            end
        end
        head_bypass = ctl.push && !ctl.flush && (wr_idx_reg == rd_idx_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            overrun_reg <= 1'b0;
            pop_valid_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            overrun_reg <= overrun_next;
            pop_valid_reg <= pop_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            if (ctl.push && !ctl.flush)
            begin
                mem[wr_idx_reg] <= push_data;
            end
            pop_data_reg <= mem[rd_idx_reg];
            head_data_reg <= head_bypass ? push_data : mem[rd_idx_next];
        end
    end

    always_comb
    begin
        head_valid = (wr_idx_reg != rd_idx_reg);
        fill_sum = {1'b0, wr_idx_reg}
            + ((wr_idx_reg >= rd_idx_reg) ? '0 : (IDX_W + 1)'(RING_DEPTH))
            - {1'b0, rd_idx_reg};
        fill_pad = FILL_PAD_W'(fill_sum[IDX_W-1:0]);
        stat.pop_valid = pop_valid_reg;
        stat.pop_data = pop_valid_reg ? pop_data_reg : '0;
        stat.head_valid = head_valid;
        stat.head_data = head_valid ? head_data_reg : '0;
        stat.fill_count = fill_pad[FILL_W-1:0];
        stat.overrun = overrun_reg;
    end

endmodule

@@ sv/tick_sampled_uart_with_rx_ring_top.sv @@
// Top level of the tick-sampled 8N1 serial port with receive ring.
// One item is one sample tick and one result item is returned for each. An item is taken
// into an input register and processed on the clock that moves it into the output stage,
// so a new item is accepted every clock while m_tready does not hold the output stage, and
// each result is registered in the output stage as its item moves there. The state that
// the result reports is the state after that tick; the ring memory has two registered read
// ports, one for the popped byte and one for the new head. The ring holds up to RING_DEPTH-1
// bytes, its contents are undefined after reset and no clearing pass is run. The bit period
// register may be written at any time and is always ready.
module tick_sampled_uart_with_rx_ring_top (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [tsu_pkg::PERIOD_W-1:0] cfg_data,       // bit_period
    input  logic s_tvalid,
    output logic s_tready,
    // rx_level, tx_load, tx_byte[7:0], pop_req, flush, zero padding
    input  logic [tsu_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // tx_level, tx_busy, tx_accepted, pop_valid, pop_data[7:0], head_valid,
    // head_data[7:0], fill_count[4:0], overrun, zero padding
    output logic [tsu_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tsu_pkg::*;

    logic [PERIOD_W-1:0] bit_period_reg;
    logic [PERIOD_W-1:0] period;

    logic in_valid_reg;
    logic [IN_W-1:0] in_data_reg;
    logic out_valid_reg;
    logic move;

    logic rx_level;
    logic tx_load;
    logic [BYTE_W-1:0] tx_byte;
    logic pop_req;
    logic flush;

    logic [COUNT_W-1:0] period_ext;
    logic [COUNT_W-1:0] tx_frame_len;
    logic [COUNT_W-1:0] rx_sample_len;

    logic [TX_FRAME_W-1:0] tx_shift_reg;
    logic [TX_FRAME_W-1:0] tx_shift_next;
    logic [COUNT_W-1:0] tx_countdown_reg;
    logic [COUNT_W-1:0] tx_countdown_next;
    logic [COUNT_W-1:0] tx_next_edge_reg;
    logic [COUNT_W-1:0] tx_next_edge_next;
    logic tx_line_reg;
    logic tx_line_next;
    logic tx_accepted_reg;
    logic tx_accepted_next;

    logic [COUNT_W-1:0] rx_countdown_reg;
    logic [COUNT_W-1:0] rx_countdown_next;
    logic [COUNT_W-1:0] rx_countdown_dec;
    logic [COUNT_W-1:0] rx_next_sample_reg;
    logic [COUNT_W-1:0] rx_next_sample_next;
    logic [BYTE_W-1:0] rx_shift_reg;
    logic [BYTE_W-1:0] rx_shift_next;
    logic rx_push;

    ring_ctl_t ring_ctl;
    ring_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bit_period_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (bit_period_reg < PERIOD_MIN)
        begin
            period = PERIOD_MIN;
        end
        else if (bit_period_reg > PERIOD_MAX)
        begin
            period = PERIOD_MAX;
        end
        else
        begin
            period = bit_period_reg;
        end
    end

    assign move = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                in_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata[IN_W-1:0];
        end
    end

    assign rx_level = in_data_reg[0];
    assign tx_load = in_data_reg[1];
    assign tx_byte = in_data_reg[9:2];
    assign pop_req = in_data_reg[10];
    assign flush = in_data_reg[11];

    assign period_ext = COUNT_W'(period);
    assign tx_frame_len = COUNT_W'(TX_FRAME_BITS * period_ext);
    assign rx_sample_len = COUNT_W'(RX_SAMPLES * period_ext);

    always_comb
    begin
        tx_shift_next = tx_shift_reg;
        tx_countdown_next = tx_countdown_reg;
        tx_next_edge_next = tx_next_edge_reg;
        tx_line_next = tx_line_reg;
        tx_accepted_next = 1'b0;
        if (tx_load && (tx_countdown_reg == '0))
        begin
            tx_shift_next = {1'b1, tx_byte, 1'b0};
            tx_countdown_next = tx_frame_len;
            tx_next_edge_next = tx_frame_len;
            tx_accepted_next = 1'b1;
        end
        if (tx_countdown_next != '0)
        begin
            if (tx_countdown_next == tx_next_edge_next)
            begin
                tx_line_next = tx_shift_next[0];
                tx_shift_next = {1'b1, tx_shift_next[TX_FRAME_W-1:1]};
                tx_next_edge_next = tx_next_edge_next - period_ext;
            end
            tx_countdown_next = tx_countdown_next - 1'b1;
        end
    end

    always_comb
    begin
        rx_countdown_next = rx_countdown_reg;
        rx_next_sample_next = rx_next_sample_reg;
        rx_shift_next = rx_shift_reg;
        rx_countdown_dec = rx_countdown_reg - 1'b1;
        rx_push = 1'b0;
        if (flush)
        begin
            rx_countdown_next = '0;
        end
        else if (rx_countdown_reg != '0)
        begin
            rx_countdown_next = rx_countdown_dec;
            if (rx_countdown_dec == '0)
            begin
                rx_push = 1'b1;
            end
            else if (rx_countdown_dec == rx_next_sample_reg)
            begin
                rx_shift_next = {rx_level, rx_shift_reg[BYTE_W-1:1]};
                rx_next_sample_next = rx_next_sample_reg - period_ext;
            end
        end
        else if (!rx_level)
        begin
            rx_next_sample_next = rx_sample_len;
            rx_countdown_next = rx_sample_len + COUNT_W'(period >> 1);
            rx_shift_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg <= '0;
            tx_countdown_reg <= '0;
            tx_next_edge_reg <= '0;
            tx_line_reg <= 1'b1;
            tx_accepted_reg <= 1'b0;
            rx_countdown_reg <= '0;
            rx_next_sample_reg <= '0;
            rx_shift_reg <= '0;
        end
        else if (move)
        begin
            tx_shift_reg <= tx_shift_next;
            tx_countdown_reg <= tx_countdown_next;
            tx_next_edge_reg <= tx_next_edge_next;
            tx_line_reg <= tx_line_next;
            tx_accepted_reg <= tx_accepted_next;
            rx_countdown_reg <= rx_countdown_next;
            rx_next_sample_reg <= rx_next_sample_next;
            rx_shift_reg <= rx_shift_next;
        end
    end

    always_comb
    begin
        ring_ctl.step = move;
        ring_ctl.flush = flush;
        ring_ctl.pop = pop_req;
        ring_ctl.push = rx_push;
    end

    tsu_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ring_ctl),
        .push_data (rx_shift_reg),
        .stat      (stat)
    );

    assign m_tdata = {
        (OUT_TDATA_W - OUT_W)'(0),
        stat.overrun,
        stat.fill_count,
        stat.head_data,
        stat.head_valid,
        stat.pop_data,
        stat.pop_valid,
        tx_accepted_reg,
        (tx_countdown_reg != '0),
        tx_line_reg
    };

`ifndef NO_ASSERTIONS
    // An accepted load puts the start bit on the line in the same tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        move && tx_accepted_next |=> !tx_line_reg && tx_countdown_reg != '0)
    else $error("start bit missing after an accepted transmit load");

    // A flush leaves the ring empty with the overrun flag cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        move && flush |=> !stat.head_valid && !stat.overrun && stat.fill_count == '0)
    else $error("ring not empty after flush");

    // Ring state changes only when an item is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> $stable(stat.overrun) && $stable(stat.fill_count))
    else $error("ring state changed without an item");
`endif

endmodule

@@ tb/tick_sampled_uart_with_rx_ring_top_test.sv @@
// Self-checking testbench for the tick-sampled serial port with receive ring.
module tick_sampled_uart_with_rx_ring_top_test;
    import tsu_pkg::*;

    typedef struct packed {
        logic flush;
        logic pop_req;
        logic [BYTE_W-1:0] tx_byte;
        logic tx_load;
        logic rx_level;
    } tick_in_t;

    typedef struct packed {
        logic overrun;
        logic [FILL_W-1:0] fill_count;
        logic [BYTE_W-1:0] head_data;
        logic head_valid;
        logic [BYTE_W-1:0] pop_data;
        logic pop_valid;
        logic tx_accepted;
        logic tx_busy;
        logic tx_level;
    } tick_out_t;

    typedef struct packed {
        logic fixed;
        tick_in_t stim;
        tick_out_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 26;
    localparam int PERIOD_SWITCH_ROW = 5;
    localparam logic [PERIOD_W-1:0] DIR_PERIOD = 5'd2;
    localparam int PHASES = 6;
    localparam int PHASE_PERIOD [PHASES] = '{1, 0, 2, 3, 25, 31};
    localparam int PHASE_TICKS [PHASES] = '{420, 80, 300, 200, 100, 50};
    localparam int PHASE_POP_PCT [PHASES] = '{1, 30, 12, 20, 30, 30};
    localparam int PHASE_FLUSH_PERMILLE [PHASES] = '{0, 10, 5, 4, 4, 4};
    localparam int IDLE_PCT = 31;
    localparam int CALM_FROM = 600;
    localparam int CALM_TO = 800;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 1000;

    // Columns: stim is {flush, pop_req, tx_byte, tx_load, rx_level}; want is
    // {overrun, fill_count, head_data, head_valid, pop_data, pop_valid,
    // tx_accepted, tx_busy, tx_level}.
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{1'b1, '{0, 0, 8'h00, 0, 1}, '{0, 5'd0, 8'h00, 0, 8'h00, 0, 0, 0, 1}},
        '{1'b1, '{0, 1, 8'h00, 0, 1}, '{0, 5'd0, 8'h00, 0, 8'h00, 0, 0, 0, 1}},
        '{1'b1, '{0, 0, 8'hFF, 1, 1}, '{0, 5'd0, 8'h00, 0, 8'h00, 0, 1, 1, 0}},
        '{1'b1, '{0, 1, 8'h00, 1, 1}, '{0, 5'd0, 8'h00, 0, 8'h00, 0, 0, 1, 0}},
        '{1'b1, '{1, 1, 8'h00, 0, 0}, '{0, 5'd0, 8'h00, 0, 8'h00, 0, 0, 1, 0}},
        '{1'b0, '{0, 0, 8'h00, 0, 0}, '0},
        '{1'b0, '{0, 0, 8'h5A, 1, 0}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 1}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 1}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 0}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 0}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 1}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 1}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 0}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 0}, '0},
        '{1'b0, '{0, 0, 8'hC3, 1, 0}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 0}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 1}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 1}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 0}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 0}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 1}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 1}, '0},
        '{1'b0, '{0, 0, 8'h00, 0, 1}, '0},
        '{1'b0, '{0, 1, 8'h00, 0, 1}, '0},
        '{1'b0, '{0, 1, 8'h00, 0, 1}, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [PERIOD_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [PERIOD_W-1:0] period_reg = PERIOD_RESET;
    logic [COUNT_W-1:0] rx_count = '0;
    logic [COUNT_W-1:0] rx_sample_at = '0;
    logic [BYTE_W-1:0] rx_bits = '0;
    logic [BYTE_W-1:0] ring_copy [RING_DEPTH] = '{default: '0};
    int wr_ptr = 0;
    int rd_ptr = 0;
    logic overrun_copy = 1'b0;
    logic [TX_FRAME_W-1:0] tx_frame = '0;
    logic [COUNT_W-1:0] tx_count = '0;
    logic [COUNT_W-1:0] tx_edge_at = '0;
    logic tx_line_copy = 1'b1;

    tick_out_t port_results_due [$];
    logic rx_wave [$];
    int ticks_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int periods_used = 1;
    int max_fill = 0;
    int bytes_popped = 0;
    logic overrun_seen = 1'b0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int stall_cycles = 0;

    tick_sampled_uart_with_rx_ring_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int eff_period(input logic [PERIOD_W-1:0] v);
        if (v < PERIOD_MIN)
            return int'(PERIOD_MIN);
        if (v > PERIOD_MAX)
            return int'(PERIOD_MAX);
        return int'(v);
    endfunction

    function automatic int ring_next(input int i);
        return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
    endfunction

    function automatic tick_out_t advance_port(input tick_in_t it);
        tick_out_t r;
        logic [COUNT_W-1:0] w;
        r = '0;
        w = COUNT_W'(eff_period(period_reg));
        if (it.tx_load && tx_count == 0)
        begin
            tx_frame = {1'b1, it.tx_byte, 1'b0};
            tx_count = TX_FRAME_BITS * w;
            tx_edge_at = tx_count;
            r.tx_accepted = 1'b1;
        end
        if (tx_count != 0)
        begin
            if (tx_count == tx_edge_at)
            begin
                tx_line_copy = tx_frame[0];
                tx_frame = {1'b1, tx_frame[TX_FRAME_W-1:1]};
                tx_edge_at = tx_edge_at - w;
            end
            tx_count = tx_count - 1'b1;
        end
        if (!it.flush && it.pop_req && wr_ptr != rd_ptr)
        begin
            r.pop_data = ring_copy[rd_ptr];
            rd_ptr = ring_next(rd_ptr);
            r.pop_valid = 1'b1;
        end
        if (it.flush)
        begin
            rx_count = '0;
            wr_ptr = 0;
            rd_ptr = 0;
            overrun_copy = 1'b0;
        end
        else if (rx_count != 0)
        begin
            rx_count = rx_count - 1'b1;
            if (rx_count == 0)
            begin
                ring_copy[wr_ptr] = rx_bits;
                wr_ptr = ring_next(wr_ptr);
                if (wr_ptr == rd_ptr)
                begin
                    overrun_copy = 1'b1;
                    rd_ptr = ring_next(rd_ptr);
                end
            end
            else if (rx_count == rx_sample_at)
            begin
                rx_bits = {it.rx_level, rx_bits[BYTE_W-1:1]};
                rx_sample_at = rx_sample_at - w;
            end
        end
        else if (!it.rx_level)
        begin
            rx_sample_at = RX_SAMPLES * w;
            rx_count = RX_SAMPLES * w + (w >> 1);
            rx_bits = '0;
        end
        r.tx_level = tx_line_copy;
        r.tx_busy = (tx_count != 0);
        r.head_valid = (wr_ptr != rd_ptr);
        r.head_data = r.head_valid ? ring_copy[rd_ptr] : '0;
        r.fill_count = FILL_W'((wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH);
        r.overrun = overrun_copy;
        return r;
    endfunction

    task automatic queue_rx_waveform(input int w, input logic tight);
        int mode;
        logic [BYTE_W-1:0] b;
        mode = $urandom_range(99);
        b = BYTE_W'($urandom_range(255));
        if (mode < 75)
        begin
            repeat (w) rx_wave.push_back(1'b0);
            for (int k = 0; k < BYTE_W; k++)
                repeat (w) rx_wave.push_back(b[k]);
            repeat (w) rx_wave.push_back(1'b1);
            repeat ($urandom_range(tight ? 1 : 2 * w)) rx_wave.push_back(1'b1);
        end
        else if (mode < 90)
        begin
            repeat (w) rx_wave.push_back(1'b0);
            repeat ($urandom_range(1, 9 * w)) rx_wave.push_back(1'($urandom_range(1)));
        end
        else
        begin
            repeat ($urandom_range(1, 30)) rx_wave.push_back(1'b1);
        end
    endtask

    task automatic send_item(input tick_in_t stim, input logic fixed, input tick_out_t want);
        tick_out_t predicted;
        while (!(ticks_sent >= CALM_FROM && ticks_sent < CALM_TO)
               && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata <= IN_TDATA_W'(stim);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = advance_port(stim);
        port_results_due.push_back(fixed ? want : predicted);
        ticks_sent++;
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] v);
        s_tvalid <= 1'b0;
        while (port_results_due.size() != 0)
            @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        period_reg = v;
        periods_used++;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] raw);
        tick_out_t want;
        tick_out_t got;
        got = tick_out_t'(raw[OUT_W-1:0]);
        if (port_results_due.size() == 0)
        begin
            $display("%0t: result item expected none actual %h", $time, raw);
            mismatches++;
        end
        else
        begin
            want = port_results_due.pop_front();
            compare_field("tx_level", want.tx_level, got.tx_level);
            compare_field("tx_busy", want.tx_busy, got.tx_busy);
            compare_field("tx_accepted", want.tx_accepted, got.tx_accepted);
            compare_field("pop_valid", want.pop_valid, got.pop_valid);
            compare_field("pop_data", want.pop_data, got.pop_data);
            compare_field("head_valid", want.head_valid, got.head_valid);
            compare_field("head_data", want.head_data, got.head_data);
            compare_field("fill_count", want.fill_count, got.fill_count);
            compare_field("overrun", want.overrun, got.overrun);
            compare_field("padding", 0, raw[OUT_TDATA_W-1:OUT_W]);
            if (int'(want.fill_count) > max_fill)
                max_fill = int'(want.fill_count);
            overrun_seen = overrun_seen | want.overrun;
            bytes_popped += int'(want.pop_valid);
        end
        results_seen++;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_result(m_tdata);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= (results_seen >= CALM_FROM && results_seen < CALM_TO)
                            || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        tick_in_t it;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == PERIOD_SWITCH_ROW)
                write_period(DIR_PERIOD);
            send_item(DIRECTED[i].stim, DIRECTED[i].fixed, DIRECTED[i].want);
        end
        for (int p = 0; p < PHASES; p++)
        begin
            write_period(PERIOD_W'(PHASE_PERIOD[p]));
            rx_wave.delete();
            for (int n = 0; n < PHASE_TICKS[p]; n++)
            begin
                if (rx_wave.size() == 0)
                    queue_rx_waveform(eff_period(period_reg), PHASE_POP_PCT[p] < 5);
                it.rx_level = rx_wave.pop_front();
                it.tx_load = ($urandom_range(99) < 30);
                it.tx_byte = BYTE_W'($urandom_range(255));
                it.pop_req = ($urandom_range(99) < PHASE_POP_PCT[p]);
                it.flush = ($urandom_range(999) < PHASE_FLUSH_PERMILLE[p]);
                send_item(it, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        while (port_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        $display("Sent %0d sample ticks under %0d bit period settings; checked %0d results.",
                 ticks_sent, periods_used, results_seen);
        $display("Ring reached %0d bytes, overrun %0s, %0d bytes popped.",
                 max_fill, overrun_seen ? "seen" : "not seen", bytes_popped);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
